### sv/cr_pkg.sv
// ----------------------------------------------------------------------------
// cr_pkg: shared types and constants for the circle rasterizer
// Step descriptor passed from the front end to the pixel emitter, plus
// opcodes and fixed output widths.
// ----------------------------------------------------------------------------
package cr_pkg;

   // output coordinate width, two's complement
   localparam int PIX_WIDTH = 14;
   localparam int COLOR_WIDTH = 32;

   // step queue depth and its pointer/count widths
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   // input opcodes
   localparam logic OP_START = 1'b0;
   localparam logic OP_ADVANCE = 1'b1;

   // index of the last result word of a step
   localparam logic [2:0] LAST_OUTLINE = 3'd7;
   localparam logic [2:0] LAST_FILL = 3'd3;

   typedef logic signed [PIX_WIDTH-1:0] pix_type;

   // one step: either a done marker or the eight mirrored coordinates
   // a = offset_x, b = offset_y
   typedef struct packed {
      logic done;
      logic fill;
      pix_type x_pa;
      pix_type x_ma;
      pix_type x_pb;
      pix_type x_mb;
      pix_type y_pa;
      pix_type y_ma;
      pix_type y_pb;
      pix_type y_mb;
      logic [COLOR_WIDTH-1:0] color;
   } step_type;

endpackage

### sv/cr_front.sv
// ----------------------------------------------------------------------------
// cr_front: circle state and step generator
// Takes start and advance words, keeps the center, offsets and decision
// term, and pushes one step descriptor per advance into the step queue.
// ----------------------------------------------------------------------------
module cr_front #(
   parameter int COORD_WIDTH = 12
) (
   input  logic clock,
   input  logic reset,
   input  logic req_push,
   output logic req_full,
   input  logic req_operation,
   input  logic [COORD_WIDTH-1:0] req_center_x,
   input  logic [COORD_WIDTH-1:0] req_center_y,
   input  logic [COORD_WIDTH-1:0] req_radius,
   input  logic req_fill_mode,
   input  logic [cr_pkg::COLOR_WIDTH-1:0] req_color,
   output logic q_push,
   output cr_pkg::step_type q_data,
   input  logic q_full
);
   import cr_pkg::*;

   localparam int OW = COORD_WIDTH + 2;             // offsets, signed
   localparam int DW = COORD_WIDTH + 3;             // decision term, signed
   localparam int AW = DW + 1;                      // decision arithmetic
   localparam int EW = (COORD_WIDTH + 3 > PIX_WIDTH) ? COORD_WIDTH + 3 : PIX_WIDTH;

   logic [COORD_WIDTH-1:0] center_col_ff, center_col_in;
   logic [COORD_WIDTH-1:0] center_row_ff, center_row_in;
   logic [COORD_WIDTH-1:0] radius_ff, radius_in;
   logic signed [OW-1:0] offset_x_ff, offset_x_in;
   logic signed [OW-1:0] offset_y_ff, offset_y_in;
   logic signed [DW-1:0] decision_ff, decision_in;
   logic fill_ff, fill_in;
   logic [COLOR_WIDTH-1:0] color_ff, color_in;
   logic active_ff, active_in;

   logic accept;
   logic complete;
   logic signed [AW-1:0] ox_e, oy_e, r_e, d_e, two_ox, two_rmy;
   logic signed [AW-1:0] d_next;
   logic signed [EW-1:0] cx_e, cy_e, ox_c, oy_c;
   logic signed [EW-1:0] x_pa, x_ma, x_pb, x_mb, y_pa, y_ma, y_pb, y_mb;

   assign req_full = q_full;
   assign accept = req_push && !q_full;
   assign complete = !active_ff || (offset_y_ff < offset_x_ff);

   // three-way decision update
   always_comb begin
      ox_e = {{(AW-OW){offset_x_ff[OW-1]}}, offset_x_ff};
      oy_e = {{(AW-OW){offset_y_ff[OW-1]}}, offset_y_ff};
      r_e = {{(AW-COORD_WIDTH){1'b0}}, radius_ff};
      d_e = {decision_ff[DW-1], decision_ff};
      two_ox = ox_e <<< 1;
      two_rmy = (r_e - oy_e) <<< 1;
      d_next = d_e;
      offset_x_in = offset_x_ff;
      offset_y_in = offset_y_ff;
      if (d_e >= two_ox) begin
         d_next = d_e - two_ox - AW'(1);
         offset_x_in = offset_x_ff + OW'(1);
      end else if (d_e < two_rmy) begin
         d_next = d_e + (oy_e <<< 1) - AW'(1);
         offset_y_in = offset_y_ff - OW'(1);
      end else begin
         d_next = d_e + ((oy_e - ox_e - AW'(1)) <<< 1);
         offset_y_in = offset_y_ff - OW'(1);
         offset_x_in = offset_x_ff + OW'(1);
      end
   end

   // mirrored coordinates, wrapped to the output width
   always_comb begin
      cx_e = {{(EW-COORD_WIDTH){1'b0}}, center_col_ff};
      cy_e = {{(EW-COORD_WIDTH){1'b0}}, center_row_ff};
      ox_c = {{(EW-OW){offset_x_ff[OW-1]}}, offset_x_ff};
      oy_c = {{(EW-OW){offset_y_ff[OW-1]}}, offset_y_ff};
      x_pa = cx_e + ox_c;
      x_ma = cx_e - ox_c;
      x_pb = cx_e + oy_c;
      x_mb = cx_e - oy_c;
      y_pa = cy_e + ox_c;
      y_ma = cy_e - ox_c;
      y_pb = cy_e + oy_c;
      y_mb = cy_e - oy_c;
   end

   // step descriptor
   always_comb begin
      q_push = accept && (req_operation == OP_ADVANCE);
      q_data.done = complete;
      q_data.fill = fill_ff;
      q_data.x_pa = x_pa[PIX_WIDTH-1:0];
      q_data.x_ma = x_ma[PIX_WIDTH-1:0];
      q_data.x_pb = x_pb[PIX_WIDTH-1:0];
      q_data.x_mb = x_mb[PIX_WIDTH-1:0];
      q_data.y_pa = y_pa[PIX_WIDTH-1:0];
      q_data.y_ma = y_ma[PIX_WIDTH-1:0];
      q_data.y_pb = y_pb[PIX_WIDTH-1:0];
      q_data.y_mb = y_mb[PIX_WIDTH-1:0];
      q_data.color = color_ff;
   end

   // next state
   always_comb begin
      center_col_in = center_col_ff;
      center_row_in = center_row_ff;
      radius_in = radius_ff;
      fill_in = fill_ff;
      color_in = color_ff;
      active_in = active_ff;
      decision_in = decision_ff;
      if (accept && (req_operation == OP_START)) begin
         center_col_in = req_center_x;
         center_row_in = req_center_y;
         radius_in = req_radius;
         fill_in = req_fill_mode;
         color_in = req_color;
         active_in = 1'b1;
         decision_in = {3'b000, req_radius} - DW'(1);
      end else if (accept && complete) begin
         active_in = 1'b0;
      end else if (accept) begin
         decision_in = d_next[DW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         center_col_ff <= '0;
         center_row_ff <= '0;
         radius_ff <= '0;
         offset_x_ff <= '0;
         offset_y_ff <= '0;
         decision_ff <= '0;
         fill_ff <= 1'b0;
         color_ff <= '0;
         active_ff <= 1'b0;
      end else begin
         center_col_ff <= center_col_in;
         center_row_ff <= center_row_in;
         radius_ff <= radius_in;
         fill_ff <= fill_in;
         color_ff <= color_in;
         active_ff <= active_in;
         decision_ff <= decision_in;
         if (accept && (req_operation == OP_START)) begin
            offset_x_ff <= '0;
            offset_y_ff <= {2'b00, req_radius};
         end else if (accept && !complete) begin
            offset_x_ff <= offset_x_in;
            offset_y_ff <= offset_y_in;
         end
      end
   end

endmodule

### sv/cr_queue.sv
// ----------------------------------------------------------------------------
// cr_queue: step descriptor queue
// Small register queue between the step generator and the pixel emitter.
// ----------------------------------------------------------------------------
module cr_queue (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  cr_pkg::step_type push_data,
   output logic full,
   input  logic pop,
   output cr_pkg::step_type pop_data,
   output logic empty
);
   import cr_pkg::*;

   step_type entry_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_WIDTH-1:0] count_ff;
   logic do_push, do_pop;

   assign full = (count_ff == QCNT_WIDTH'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_WIDTH'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_WIDTH'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + QCNT_WIDTH'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - QCNT_WIDTH'(1);
         end
      end
   end

`ifndef SYNTHESIS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push && full)) else $error("step pushed into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty)) else $error("step popped from empty queue");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_WIDTH'(QUEUE_DEPTH)) else $error("queue count overflow");
`endif

endmodule

### sv/cr_back.sv
// ----------------------------------------------------------------------------
// cr_back: pixel emitter
// Walks one step descriptor into an output register, one result word per
// cycle while that register is drained through the empty/pop interface.
// ----------------------------------------------------------------------------
module cr_back (
   input  logic clock,
   input  logic reset,
   input  logic q_empty,
   input  cr_pkg::step_type q_data,
   output logic q_pop,
   output logic rsp_empty,
   input  logic rsp_pop,
   output logic signed [cr_pkg::PIX_WIDTH-1:0] rsp_pixel_x,
   output logic signed [cr_pkg::PIX_WIDTH-1:0] rsp_pixel_y,
   output logic signed [cr_pkg::PIX_WIDTH-1:0] rsp_span_end_x,
   output logic [cr_pkg::COLOR_WIDTH-1:0] rsp_pixel_color,
   output logic rsp_finished,
   output logic rsp_last_of_step
);
   import cr_pkg::*;

   step_type cur_ff;
   logic cur_valid_ff;
   logic [2:0] idx_ff;
   logic out_valid_ff;
   pix_type px_ff, py_ff, ex_ff;
   logic [COLOR_WIDTH-1:0] color_ff;
   logic finished_ff, last_ff;

   logic take, last;
   pix_type px_in, py_in, ex_in;

   assign take = cur_valid_ff && (!out_valid_ff || rsp_pop);
   assign last = cur_ff.done || (cur_ff.fill ? (idx_ff == LAST_FILL)
                                             : (idx_ff == LAST_OUTLINE));
   assign q_pop = !q_empty && (!cur_valid_ff || (take && last));

   // result select for the current index
   always_comb begin
      px_in = '0;
      py_in = '0;
      ex_in = '0;
      if (cur_ff.fill) begin
         case (idx_ff[1:0])
            2'd0: begin px_in = cur_ff.x_mb; py_in = cur_ff.y_pa; ex_in = cur_ff.x_pb; end
            2'd1: begin px_in = cur_ff.x_ma; py_in = cur_ff.y_pb; ex_in = cur_ff.x_pa; end
            2'd2: begin px_in = cur_ff.x_ma; py_in = cur_ff.y_mb; ex_in = cur_ff.x_pa; end
            2'd3: begin px_in = cur_ff.x_mb; py_in = cur_ff.y_ma; ex_in = cur_ff.x_pb; end
            default: begin px_in = '0; py_in = '0; ex_in = '0; end
         endcase
      end else begin
         case (idx_ff)
            3'd0: begin px_in = cur_ff.x_pa; py_in = cur_ff.y_pb; end
            3'd1: begin px_in = cur_ff.x_pb; py_in = cur_ff.y_pa; end
            3'd2: begin px_in = cur_ff.x_ma; py_in = cur_ff.y_pb; end
            3'd3: begin px_in = cur_ff.x_mb; py_in = cur_ff.y_pa; end
            3'd4: begin px_in = cur_ff.x_pa; py_in = cur_ff.y_mb; end
            3'd5: begin px_in = cur_ff.x_pb; py_in = cur_ff.y_ma; end
            3'd6: begin px_in = cur_ff.x_ma; py_in = cur_ff.y_mb; end
            3'd7: begin px_in = cur_ff.x_mb; py_in = cur_ff.y_ma; end
            default: begin px_in = '0; py_in = '0; end
         endcase
         ex_in = px_in;
      end
   end

   // walker control and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
         // a new descriptor replaces the finished one in the same cycle
         if (q_pop) begin
            cur_valid_ff <= 1'b1;
            idx_ff <= '0;
         end else if (take && last) begin
            cur_valid_ff <= 1'b0;
            idx_ff <= '0;
         end else if (take) begin
            idx_ff <= idx_ff + 3'd1;
         end
      end
   end

   // descriptor and result payload
   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_data;
      end
      if (take) begin
         finished_ff <= cur_ff.done;
         last_ff <= last;
         if (cur_ff.done) begin
            px_ff <= '0;
            py_ff <= '0;
            ex_ff <= '0;
            color_ff <= '0;
         end else begin
            px_ff <= px_in;
            py_ff <= py_in;
            ex_ff <= ex_in;
            color_ff <= cur_ff.color;
         end
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_pixel_x = px_ff;
   assign rsp_pixel_y = py_ff;
   assign rsp_span_end_x = ex_ff;
   assign rsp_pixel_color = color_ff;
   assign rsp_finished = finished_ff;
   assign rsp_last_of_step = last_ff;

`ifndef SYNTHESIS
   a_fill_index: assert property (@(posedge clock) disable iff (reset)
      (cur_valid_ff && cur_ff.fill) |-> (idx_ff <= LAST_FILL))
      else $error("fill step index past last span");
   a_done_alone: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_finished) |-> (rsp_last_of_step && rsp_pixel_color == '0))
      else $error("done word carries geometry or is not last");
   a_pop_on_boundary: assert property (@(posedge clock) disable iff (reset)
      (q_pop && cur_valid_ff) |-> (take && last))
      else $error("descriptor replaced mid-step");
`endif

endmodule

### sv/circle_rasterizer.sv
// Result path: an advance word goes through the step queue and the emitter's
// current step into its output register; a start word produces no result.
// Throughput: one emitter result word per cycle while results are popped; an
// outline step gives eight words, a fill step four, a done word one; the step
// queue lets the front end take words back to back until it holds 4 steps.
// Reset: synchronous, clears the circle state, the queue and the output valid.
// ----------------------------------------------------------------------------
// circle_rasterizer: midpoint circle generator, three-way decision rule
// Front end keeps circle state and builds step descriptors; the emitter
// walks each step into outline pixels or fill spans.
// ----------------------------------------------------------------------------
module circle_rasterizer #(
   parameter int COORD_WIDTH = 12
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   output logic full,
   input  logic req_operation,
   input  logic [COORD_WIDTH-1:0] req_center_x,
   input  logic [COORD_WIDTH-1:0] req_center_y,
   input  logic [COORD_WIDTH-1:0] req_radius,
   input  logic req_fill_mode,
   input  logic [cr_pkg::COLOR_WIDTH-1:0] req_color,
   output logic empty,
   input  logic pop,
   output logic signed [cr_pkg::PIX_WIDTH-1:0] rsp_pixel_x,
   output logic signed [cr_pkg::PIX_WIDTH-1:0] rsp_pixel_y,
   output logic signed [cr_pkg::PIX_WIDTH-1:0] rsp_span_end_x,
   output logic [cr_pkg::COLOR_WIDTH-1:0] rsp_pixel_color,
   output logic rsp_finished,
   output logic rsp_last_of_step
);
   import cr_pkg::*;

   logic q_push, q_full, q_pop, q_empty;
   step_type q_wdata, q_rdata;

   // step generator
   cr_front #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_push(push),
      .req_full(full),
      .req_operation(req_operation),
      .req_center_x(req_center_x),
      .req_center_y(req_center_y),
      .req_radius(req_radius),
      .req_fill_mode(req_fill_mode),
      .req_color(req_color),
      .q_push(q_push),
      .q_data(q_wdata),
      .q_full(q_full)
   );

   // step queue
   cr_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .push_data(q_wdata),
      .full(q_full),
      .pop(q_pop),
      .pop_data(q_rdata),
      .empty(q_empty)
   );

   // pixel emitter
   cr_back u_back (
      .clock(clock),
      .reset(reset),
      .q_empty(q_empty),
      .q_data(q_rdata),
      .q_pop(q_pop),
      .rsp_empty(empty),
      .rsp_pop(pop),
      .rsp_pixel_x(rsp_pixel_x),
      .rsp_pixel_y(rsp_pixel_y),
      .rsp_span_end_x(rsp_span_end_x),
      .rsp_pixel_color(rsp_pixel_color),
      .rsp_finished(rsp_finished),
      .rsp_last_of_step(rsp_last_of_step)
   );

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for circle_rasterizer
// Drives start and advance words through the push/full side, pops result
// words with random stalls and compares each one against an in-bench
// midpoint circle predictor (three-way decision rule, outline and fill).
// ----------------------------------------------------------------------------
module tb;
   import cr_pkg::*;

   localparam int CW = 12;
   localparam int RANDOM_WORDS = 270;
   localparam int CYCLE_LIMIT = 600000;

   // one expected result word
   typedef struct {
      pix_type x;
      pix_type y;
      pix_type x_end;
      logic [COLOR_WIDTH-1:0] color;
      logic finished;
      logic last;
   } pixel_word_type;

   logic clock = 1'b0;
   logic reset;
   logic push;
   logic full;
   logic req_operation;
   logic [CW-1:0] req_center_x;
   logic [CW-1:0] req_center_y;
   logic [CW-1:0] req_radius;
   logic req_fill_mode;
   logic [COLOR_WIDTH-1:0] req_color;
   logic empty;
   logic pop;
   logic signed [PIX_WIDTH-1:0] rsp_pixel_x;
   logic signed [PIX_WIDTH-1:0] rsp_pixel_y;
   logic signed [PIX_WIDTH-1:0] rsp_span_end_x;
   logic [COLOR_WIDTH-1:0] rsp_pixel_color;
   logic rsp_finished;
   logic rsp_last_of_step;

   // predictor copy of the circle state
   int ctr_col;
   int ctr_row;
   int rad;
   int off_x;
   int off_y;
   int dec_term;
   logic fill_on;
   logic [COLOR_WIDTH-1:0] ink;
   logic drawing;

   pixel_word_type pixel_q[$];
   pixel_word_type got_word;
   int fail_count = 0;
   int words_sent = 0;
   int cycles = 0;
   logic calm = 1'b0;

   circle_rasterizer #(
      .COORD_WIDTH(CW)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_operation(req_operation),
      .req_center_x(req_center_x),
      .req_center_y(req_center_y),
      .req_radius(req_radius),
      .req_fill_mode(req_fill_mode),
      .req_color(req_color),
      .empty(empty),
      .pop(pop),
      .rsp_pixel_x(rsp_pixel_x),
      .rsp_pixel_y(rsp_pixel_y),
      .rsp_span_end_x(rsp_span_end_x),
      .rsp_pixel_color(rsp_pixel_color),
      .rsp_finished(rsp_finished),
      .rsp_last_of_step(rsp_last_of_step)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run guard
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // mostly short gaps, a few long ones, none while calm
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // append one expected word, coordinates wrapped to the port width
   task automatic queue_pixel(input int px, input int py, input int ex,
                              input logic [COLOR_WIDTH-1:0] col,
                              input logic fin, input logic last);
      pixel_word_type w;
      w.x = px[PIX_WIDTH-1:0];
      w.y = py[PIX_WIDTH-1:0];
      w.x_end = ex[PIX_WIDTH-1:0];
      w.color = col;
      w.finished = fin;
      w.last = last;
      pixel_q.push_back(w);
   endtask

   // circle predictor: start loads state, advance emits one step then moves
   task automatic model_circle_word(input logic op, input logic [CW-1:0] cx,
                                    input logic [CW-1:0] cy,
                                    input logic [CW-1:0] r, input logic fill,
                                    input logic [COLOR_WIDTH-1:0] col);
      int x;
      int y;
      int a;
      int b;
      if (op == OP_START) begin
         ctr_col = cx;
         ctr_row = cy;
         rad = r;
         fill_on = fill;
         ink = col;
         off_x = 0;
         off_y = rad;
         dec_term = rad - 1;
         drawing = 1'b1;
         return;
      end
      // circle complete, or no circle at all
      if (!drawing || off_y < off_x) begin
         drawing = 1'b0;
         queue_pixel(0, 0, 0, '0, 1'b1, 1'b1);
         return;
      end
      x = ctr_col;
      y = ctr_row;
      a = off_x;
      b = off_y;
      if (fill_on) begin
         queue_pixel(x - b, y + a, x + b, ink, 1'b0, 1'b0);
         queue_pixel(x - a, y + b, x + a, ink, 1'b0, 1'b0);
         queue_pixel(x - a, y - b, x + a, ink, 1'b0, 1'b0);
         queue_pixel(x - b, y - a, x + b, ink, 1'b0, 1'b1);
      end else begin
         queue_pixel(x + a, y + b, x + a, ink, 1'b0, 1'b0);
         queue_pixel(x + b, y + a, x + b, ink, 1'b0, 1'b0);
         queue_pixel(x - a, y + b, x - a, ink, 1'b0, 1'b0);
         queue_pixel(x - b, y + a, x - b, ink, 1'b0, 1'b0);
         queue_pixel(x + a, y - b, x + a, ink, 1'b0, 1'b0);
         queue_pixel(x + b, y - a, x + b, ink, 1'b0, 1'b0);
         queue_pixel(x - a, y - b, x - a, ink, 1'b0, 1'b0);
         queue_pixel(x - b, y - a, x - b, ink, 1'b0, 1'b1);
      end
      // three-way decision update
      if (dec_term >= 2 * a) begin
         dec_term -= 2 * a + 1;
         off_x = a + 1;
      end else if (dec_term < 2 * (rad - b)) begin
         dec_term += 2 * b - 1;
         off_y = b - 1;
      end else begin
         dec_term += 2 * (b - a - 1);
         off_y = b - 1;
         off_x = a + 1;
      end
   endtask

   // drive one word and hold it until the block takes it
   task automatic send_word(input logic op, input logic [CW-1:0] cx,
                            input logic [CW-1:0] cy, input logic [CW-1:0] r,
                            input logic fill, input logic [COLOR_WIDTH-1:0] col);
      int gap;
      gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         push <= 1'b0;
      end
      @(negedge clock);
      push <= 1'b1;
      req_operation <= op;
      req_center_x <= cx;
      req_center_y <= cy;
      req_radius <= r;
      req_fill_mode <= fill;
      req_color <= col;
      do @(posedge clock); while (full);
      model_circle_word(op, cx, cy, r, fill, col);
      words_sent++;
   endtask

   // advance word; the unused fields carry noise
   task automatic send_advance();
      send_word(OP_ADVANCE, CW'($urandom), CW'($urandom), CW'($urandom),
                1'($urandom), $urandom);
   endtask

   // start a circle, then advance up to max_steps times or until done
   task automatic draw_circle(input logic [CW-1:0] cx, input logic [CW-1:0] cy,
                              input logic [CW-1:0] r, input logic fill,
                              input logic [COLOR_WIDTH-1:0] col,
                              input int max_steps);
      int n;
      n = 0;
      send_word(OP_START, cx, cy, r, fill, col);
      while (drawing && n < max_steps) begin
         send_advance();
         n++;
      end
   endtask

   // drop push first so the last word is not taken again while waiting
   task automatic wait_drained();
      @(negedge clock);
      push <= 1'b0;
      while (pixel_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // advance with no circle loaded reports done, twice over
   task automatic test_idle_advance();
      send_advance();
      send_advance();
   endtask

   // zero radius: center repeated, then done, then done with no circle
   task automatic test_zero_radius();
      draw_circle('0, '0, '0, 1'b0, 32'h0000_0000, 1);
      send_advance();
      send_advance();
      draw_circle('1, '1, '0, 1'b1, 32'hFFFF_FFFF, 1);
      send_advance();
   endtask

   // largest radius at the corners; coordinates wrap, starts abandon circles
   task automatic test_extreme_radius();
      draw_circle('0, '0, '1, 1'b0, 32'hA5A5_5A5A, 2);
      draw_circle('1, '1, '1, 1'b1, 32'h5A5A_A5A5, 2);
      draw_circle('0, '1, '1, 1'b0, 32'h0123_4567, 1);
   endtask

   // small circles run to completion in both modes
   task automatic test_small_circles();
      draw_circle(12'd100, 12'd200, 12'd1, 1'b1, 32'h89AB_CDEF, 100);
      draw_circle(12'd2048, 12'd2048, 12'd3, 1'b0, 32'hFEDC_BA98, 100);
   endtask

   // no gaps on either side
   task automatic test_back_to_back();
      calm = 1'b1;
      draw_circle(CW'($urandom), CW'($urandom), CW'($urandom_range(4, 12)),
                  1'b0, $urandom, 100);
      draw_circle(CW'($urandom), CW'($urandom), CW'($urandom_range(4, 12)),
                  1'b1, $urandom, 100);
      calm = 1'b0;
   endtask

   // sender holds off until every expected word has been popped
   task automatic test_drain_pause();
      draw_circle(CW'($urandom), CW'($urandom), CW'($urandom_range(2, 8)),
                  1'($urandom), $urandom, 100);
      wait_drained();
      draw_circle(CW'($urandom), CW'($urandom), CW'($urandom_range(2, 8)),
                  1'($urandom), $urandom, 100);
   endtask

   // mostly whole small circles, some abandoned, some huge, some stray advances
   task automatic test_random_circles();
      int stop_at;
      int k;
      stop_at = words_sent + RANDOM_WORDS;
      while (words_sent < stop_at) begin
         k = $urandom_range(0, 99);
         if (k < 8) begin
            draw_circle(CW'($urandom), CW'($urandom), CW'($urandom),
                        1'($urandom), $urandom, $urandom_range(1, 6));
         end else if (k < 15) begin
            send_advance();
         end else if (k < 30) begin
            draw_circle(CW'($urandom), CW'($urandom), CW'($urandom_range(0, 20)),
                        1'($urandom), $urandom, $urandom_range(1, 4));
         end else begin
            draw_circle(CW'($urandom), CW'($urandom), CW'($urandom_range(0, 20)),
                        1'($urandom), $urandom, 1000);
            if ($urandom_range(0, 4) == 0) send_advance();
         end
      end
   endtask

   // result side: random pop stalls
   initial begin
      int gap;
      pop = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         gap = pick_gap();
         if (gap > 0) begin
            pop <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
         @(negedge clock);
      end
   end

   task automatic check_field(input string name, input longint want,
                              input longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   // compare each popped word with the oldest expectation
   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         if (pixel_q.size() == 0) begin
            $error("result word with no expectation waiting");
            fail_count++;
         end else begin
            got_word = pixel_q.pop_front();
            check_field("pixel_x", got_word.x, rsp_pixel_x);
            check_field("pixel_y", got_word.y, rsp_pixel_y);
            check_field("span_end_x", got_word.x_end, rsp_span_end_x);
            check_field("pixel_color", got_word.color, rsp_pixel_color);
            check_field("finished", got_word.finished, rsp_finished);
            check_field("last_of_step", got_word.last, rsp_last_of_step);
         end
      end
   end

   // main sequence
   initial begin
      reset = 1'b1;
      push = 1'b0;
      req_operation = OP_START;
      req_center_x = '0;
      req_center_y = '0;
      req_radius = '0;
      req_fill_mode = 1'b0;
      req_color = '0;
      ctr_col = 0;
      ctr_row = 0;
      rad = 0;
      off_x = 0;
      off_y = 0;
      dec_term = 0;
      fill_on = 1'b0;
      ink = '0;
      drawing = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_idle_advance();
      test_zero_radius();
      test_extreme_radius();
      test_small_circles();
      test_back_to_back();
      test_drain_pause();
      test_random_circles();

      @(negedge clock);
      push <= 1'b0;
      wait_drained();
      if (pixel_q.size() != 0) begin
         $error("%0d expected words never arrived", pixel_q.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
